>>> rtl/core/bsev_pkg.sv
// bsev_pkg: shared types, constants and arithmetic helpers of the Bezier spline evaluator.
// Depends on nothing; imported by every module in rtl/core.
package bsev_pkg;

    localparam int STORE_DEPTH = 27;   // control points in the store
    localparam int IDX_W       = 5;    // store index width
    localparam int ADDR_W      = 7;    // segment point address, up to 3*31+5
    localparam int SEG_W       = 5;    // segment number, up to 31
    localparam int COORD_W     = 32;   // Q15.16 coordinate
    localparam int T_W         = 24;   // Q7.16 parameter
    localparam int FRAC_BITS   = 16;
    localparam int GUARD_BITS  = 8;    // extra fraction bits inside the datapath
    localparam int U_W         = FRAC_BITS + 1;  // fraction 0..1.0 inclusive
    localparam int W_W         = 48;   // internal point width, Q.24
    localparam int PROD_W      = W_W + U_W + 2;
    localparam int ACC_W       = 58;   // derivative accumulator width
    localparam int OUT_W       = 48;   // Q31.16 result
    localparam int NAX         = 2;    // x, y
    localparam int NPT         = 6;    // points of a quintic segment
    localparam int AX_X        = 0;
    localparam int AX_Y        = 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef logic signed [W_W-1:0]     t_w;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]   t_acc;

    typedef struct packed {
        logic                      operation;
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [T_W-1:0]     param_t;
    } t_cmd;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] vel_x;
        logic signed [OUT_W-1:0] vel_y;
        logic signed [OUT_W-1:0] acc_x;
        logic signed [OUT_W-1:0] acc_y;
    } t_res;

    // sideband that travels with every stage
    typedef struct packed {
        logic           vld;
        logic           qm;   // quintic segment
        logic [U_W-1:0] u;
    } t_ctl;

    // a + round((b - a) * u), u in unsigned Q1.16 (0..1.0 inclusive)
    function automatic t_w lerp(t_w a, t_w b, logic [U_W-1:0] u);
        logic signed [W_W:0]      d;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        d = {b[W_W-1], b} - {a[W_W-1], a};
        p = d * $signed({1'b0, u});
        q = (p + PROD_W'(32768)) >>> FRAC_BITS;
        return a + q[W_W-1:0];
    endfunction

    // drop guard bits with round half up, keep 48 bits
    function automatic logic [OUT_W-1:0] round_out(t_acc x);
        t_acc s;
        s = x + ACC_W'(128);
        return s[GUARD_BITS+OUT_W-1:GUARD_BITS];
    endfunction

endpackage

>>> rtl/core/bsev_mem.sv
// bsev_mem: control point store, three banks of two read ports, registered reads.
// Depends on bsev_pkg.
module bsev_mem
    import bsev_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  t_coord            i_wx,
    input  t_coord            i_wy,
    input  logic [ADDR_W-1:0] i_base,
    output t_coord            o_pt  [NAX][NPT],
    output logic [NPT-1:0]    o_oor
);

    for (genvar g = 0; g < NPT / 2; g++) begin : g_bank
        logic [2*COORD_W-1:0] mem [STORE_DEPTH];
        logic [2*COORD_W-1:0] r_rd [2];
        logic [1:0]           r_oor;
        logic [ADDR_W-1:0]    a [2];
        logic [IDX_W-1:0]     ra [2];

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                a[k]  = i_base + ADDR_W'(2 * g + k);
                ra[k] = (a[k] < ADDR_W'(STORE_DEPTH)) ? a[k][IDX_W-1:0] : '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_we && i_waddr < IDX_W'(STORE_DEPTH)) begin
                mem[i_waddr] <= {i_wx, i_wy};
            end
            for (int k = 0; k < 2; k++) begin
                r_rd[k]  <= mem[ra[k]];
                r_oor[k] <= (a[k] >= ADDR_W'(STORE_DEPTH));
            end
        end

        for (genvar k = 0; k < 2; k++) begin : g_port
            assign o_pt[AX_X][2*g+k] = r_rd[k][2*COORD_W-1:COORD_W];
            assign o_pt[AX_Y][2*g+k] = r_rd[k][COORD_W-1:0];
            assign o_oor[2*g+k]      = r_oor[k];
        end
    end

endmodule

>>> rtl/core/bsev_level.sv
// bsev_level: one registered de Casteljau reduction level on both axes; with i_en low it only registers the points.
// Depends on bsev_pkg.
module bsev_level
    import bsev_pkg::*;
#(
    parameter int M = 5   // lerp lanes in this level
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_ctl i_ctl,
    input  t_w   i_w [NAX][NPT],
    output t_ctl o_ctl,
    output t_w   o_w [NAX][NPT]
);

    t_ctl r_ctl;
    t_w   r_w [NAX][NPT];
    t_w   n_w [NAX][NPT];

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            for (int i = 0; i < NPT; i++) begin
                if (i < M && i_en) begin
                    n_w[a][i] = lerp(i_w[a][i], i_w[a][i+1], i_ctl.u);
                end else begin
                    n_w[a][i] = i_w[a][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else begin
            r_ctl.vld <= i_ctl.vld;
        end
        r_ctl.qm <= i_ctl.qm;
        r_ctl.u  <= i_ctl.u;
        r_w      <= n_w;
    end

    assign o_ctl = r_ctl;
    assign o_w   = r_w;

endmodule

>>> rtl/core/bezier_spline_eval_2d.sv
// bezier_spline_eval_2d: top level of the 2-D piecewise Bezier spline evaluator.
// Depends on bsev_pkg, bsev_mem, bsev_level.
//
// Loads write one control point word into the 27-entry store; evaluates return one
// result word (position, first and second derivative, Q31.16) at the end of the pipe,
// marked by o_valid for one cycle. o_busy is always low: a new word is taken every
// cycle, loads and evaluates mixed freely, and a load is visible to an evaluate
// started in the next cycle. The pipe runs through store read, point setup,
// three de Casteljau levels (the first two only in quintic mode), the last reduction
// with the second derivative, and output rounding. Negative t evaluates segment 0 at
// its start; t whose integer part is NUM_SEGMENTS or more evaluates the last segment
// at its end. Segment points beyond the store read as zero; a never-written entry
// reads as garbage. Switch quintic_mode only while no evaluate is in flight.
module bezier_spline_eval_2d
    import bsev_pkg::*;
#(
    parameter int NUM_SEGMENTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    output logic o_busy,
    output logic o_valid,
    output t_res o_result,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    localparam int LAT = 7;

    // config register
    logic r_qm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qm <= 1'b0;
        end else if (i_cfg_we) begin
            r_qm <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    // ---- stage A: segment select, store read ----
    logic              acc_in;
    logic [SEG_W-1:0]  seg;
    logic [U_W-1:0]    u;
    logic [ADDR_W-1:0] base;

    assign acc_in = i_start && !o_busy;

    always_comb begin
        if (i_cmd.param_t[T_W-1]) begin
            seg = '0;
            u   = '0;
        end else if (i_cmd.param_t[T_W-2:FRAC_BITS] >= (T_W-1-FRAC_BITS)'(NUM_SEGMENTS)) begin
            seg = SEG_W'(NUM_SEGMENTS - 1);
            u   = {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
            seg = i_cmd.param_t[FRAC_BITS+SEG_W-1:FRAC_BITS];
            u   = {1'b0, i_cmd.param_t[FRAC_BITS-1:0]};
        end
        base = ADDR_W'({seg, 1'b0}) + ADDR_W'(seg);   // 3 * seg
    end

    t_coord         m_pt [NAX][NPT];
    logic [NPT-1:0] m_oor;

    bsev_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (acc_in && i_cmd.operation == OP_LOAD),
        .i_waddr (i_cmd.point_index),
        .i_wx    (i_cmd.coord_x),
        .i_wy    (i_cmd.coord_y),
        .i_base  (base),
        .o_pt    (m_pt),
        .o_oor   (m_oor)
    );

    t_ctl r_a_ctl;
    logic r_a_seg0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.vld <= 1'b0;
        end else begin
            r_a_ctl.vld <= acc_in && i_cmd.operation == OP_EVAL;
        end
        r_a_ctl.qm <= r_qm;
        r_a_ctl.u  <= u;
        r_a_seg0   <= (seg == '0);
    end

    // ---- stage B: widen to Q.24, build quintic joins ----
    t_w   f [NAX][NPT];
    t_w   n_b_w [NAX][NPT];
    t_w   r_b_w [NAX][NPT];
    t_ctl r_b_ctl;

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            for (int i = 0; i < NPT; i++) begin
                f[a][i] = m_oor[i] ? '0 : (W_W'(m_pt[a][i]) <<< GUARD_BITS);
                n_b_w[a][i] = f[a][i];
            end
            if (r_a_ctl.qm && !r_a_seg0) begin
                n_b_w[a][0] = f[a][2];
                n_b_w[a][1] = (f[a][2] <<< 1) - f[a][1];
                n_b_w[a][2] = (f[a][2] <<< 2) - (f[a][1] <<< 2) + f[a][0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.vld <= 1'b0;
        end else begin
            r_b_ctl.vld <= r_a_ctl.vld;
        end
        r_b_ctl.qm <= r_a_ctl.qm;
        r_b_ctl.u  <= r_a_ctl.u;
        r_b_w      <= n_b_w;
    end

    // ---- stages C..E: reduction to three points ----
    t_ctl c_ctl, d_ctl, e_ctl;
    t_w   c_w [NAX][NPT];
    t_w   d_w [NAX][NPT];
    t_w   e_w [NAX][NPT];

    bsev_level #(.M(5)) u_lvl5 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (r_b_ctl.qm),
        .i_ctl (r_b_ctl), .i_w (r_b_w), .o_ctl (c_ctl), .o_w (c_w)
    );
    bsev_level #(.M(4)) u_lvl4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (c_ctl.qm),
        .i_ctl (c_ctl), .i_w (c_w), .o_ctl (d_ctl), .o_w (d_w)
    );
    bsev_level #(.M(3)) u_lvl3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (1'b1),
        .i_ctl (d_ctl), .i_w (d_w), .o_ctl (e_ctl), .o_w (e_w)
    );

    // ---- stage F: second derivative, reduction to two points ----
    t_acc dd [NAX];
    t_acc n_f_acc [NAX];
    t_acc r_f_acc [NAX];
    t_w   r_f_w0 [NAX];
    t_w   r_f_w1 [NAX];
    t_ctl r_f_ctl;

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            dd[a] = ACC_W'(e_w[a][2]) - (ACC_W'(e_w[a][1]) <<< 1) + ACC_W'(e_w[a][0]);
            // n(n-1): 20 quintic, 6 cubic
            n_f_acc[a] = e_ctl.qm ? (dd[a] <<< 4) + (dd[a] <<< 2)
                                  : (dd[a] <<< 2) + (dd[a] <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl.vld <= 1'b0;
        end else begin
            r_f_ctl.vld <= e_ctl.vld;
        end
        r_f_ctl.qm <= e_ctl.qm;
        r_f_ctl.u  <= e_ctl.u;
        r_f_acc    <= n_f_acc;
        for (int a = 0; a < NAX; a++) begin
            r_f_w0[a] <= lerp(e_w[a][0], e_w[a][1], e_ctl.u);
            r_f_w1[a] <= lerp(e_w[a][1], e_w[a][2], e_ctl.u);
        end
    end

    // ---- stage G: position, first derivative, rounding ----
    t_acc dv [NAX];
    t_acc vel [NAX];
    t_acc pos [NAX];
    logic r_o_vld;
    t_res r_o_res;

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            dv[a]  = ACC_W'(r_f_w1[a]) - ACC_W'(r_f_w0[a]);
            vel[a] = r_f_ctl.qm ? (dv[a] <<< 2) + dv[a] : (dv[a] <<< 1) + dv[a];
            pos[a] = ACC_W'(lerp(r_f_w0[a], r_f_w1[a], r_f_ctl.u));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_f_ctl.vld;
        end
        r_o_res.pos_x <= round_out(pos[AX_X]);
        r_o_res.pos_y <= round_out(pos[AX_Y]);
        r_o_res.vel_x <= round_out(vel[AX_X]);
        r_o_res.vel_y <= round_out(vel[AX_Y]);
        r_o_res.acc_x <= round_out(r_f_acc[AX_X]);
        r_o_res.acc_y <= round_out(r_f_acc[AX_Y]);
    end

    assign o_valid  = r_o_vld;
    assign o_result = r_o_res;

    // ---- checks ----
    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.operation == OP_EVAL) |-> ##LAT o_valid)
        else $error("evaluate word produced no result");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.operation == OP_LOAD) |-> ##LAT !o_valid)
        else $error("load word produced a result");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_start) |-> ##LAT !o_valid)
        else $error("result without an evaluate word");

endmodule
